FILE: src/invertible_bloom_filter_top_assert.svh
// Assertion macros for the invertible Bloom filter block.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef INVERTIBLE_BLOOM_FILTER_TOP_ASSERT_SVH
`define INVERTIBLE_BLOOM_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ibf assertion failed");
`define IBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibf assertion failed");
`else
`define IBF_ASSERT(lbl, prop)
`define IBF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/ibf_pkg.sv
// Shared types, codes and the CRC-32 byte step of the invertible Bloom filter.
// Depends on nothing.
package ibf_pkg;

  localparam int BUCKETS_DEF    = 1024;
  localparam int MAX_HASHES_DEF = 8;
  localparam int ROUND_LIMIT    = 256;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [1:0] CFG_HASH_COUNT = 2'd0;
  localparam logic [1:0] CFG_BUCKETS    = 2'd1;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_DECODE   = 3'd2,
    OP_LOAD     = 3'd3,
    OP_SUBTRACT = 3'd4,
    OP_READ     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DECODED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FAILED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  count;
    logic [63:0] key;
    logic [31:0] hash;
  } bucket_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: src/invertible_bloom_filter_top.sv
// Top level of the invertible Bloom filter: control sequencer over one bucket RAM.
// Depends on ibf_pkg, ibf_ram and invertible_bloom_filter_top_assert.svh.
//
// Usage: an input word is taken when in_valid_i is high and in_stall_o is low;
// in_stall_o is low only while the block is idle. Each input word yields one
// result word on out_valid_o, held until out_stall_i is low. A result may wait
// in the output register while the next input word is accepted.
// Configuration writes on cfg_valid_i (cfg_ready_o is always high) should
// only be made while idle; they take effect at the next accepted word.
// Bucket load, subtract and read pass through S_BK_RD and S_BK_EX to S_DONE;
// an index outside the buckets in use goes straight to S_DONE. Insert and
// remove run CRC rounds, each a byte-wise CRC and a bit-serial modulo
// reduction, typically hash_count rounds, then a key hash and an update of
// each bucket in the list. Decode scans the buckets, adding a key hash and
// the index chain for each bucket that looks pure. The block works on one
// word at a time. After reset the block clears the bucket RAM, one entry per
// cycle, with in_stall_o high. A stalled result stays in place.
`include "invertible_bloom_filter_top_assert.svh"
module invertible_bloom_filter_top #(
  parameter int BUCKETS    = ibf_pkg::BUCKETS_DEF,
  parameter int MAX_HASHES = ibf_pkg::MAX_HASHES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic [63:0]        element_key_i,
  input  logic [9:0]         bucket_index_i,
  input  logic signed [7:0]  bucket_count_in_i,
  input  logic [31:0]        bucket_hash_in_i,
  input  logic [63:0]        bucket_key_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [1:0]  decoded_side_o,
  output logic [63:0]        decoded_key_o,
  output logic signed [7:0]  bucket_count_out_o,
  output logic [31:0]        bucket_hash_out_o,
  output logic [63:0]        bucket_key_out_o
);
  import ibf_pkg::*;

  localparam int AW = $clog2(BUCKETS);
  localparam int NW = $clog2(BUCKETS + 1);
  localparam int KW = $clog2(MAX_HASHES + 1);
  localparam int JW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int RW = $clog2(ROUND_LIMIT + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CRC, S_IX_START, S_IX_MOD, S_DIV, S_IX_CHK,
    S_HASH_ST, S_HASH_END, S_AP_RD, S_AP_WR, S_SC_RD, S_SC_CHK,
    S_SC_HASH, S_SC_HIT, S_BK_RD, S_BK_EX, S_DONE
  } state_e;

  state_e          state_q, crc_ret_q, ix_ret_q;
  logic [AW-1:0]   clr_q;
  logic [3:0]      hash_count_q;
  logic [10:0]     buckets_q;
  logic [NW-1:0]   n_eff, n_q;
  logic [KW-1:0]   k_eff, k_q;
  logic [4:0]      k_tmp;
  op_e             op_q;
  logic [63:0]     key_q;
  logic [9:0]      bi_q;
  logic [7:0]      cin_q;
  logic [31:0]     hin_q;
  logic [63:0]     kin_q;
  logic [7:0]      delta_q;
  logic [31:0]     h_q, hsum_q;
  logic [7:0]      pure_cnt_q;
  logic [31:0]     crc_q;
  logic [63:0]     crc_data_q;
  logic [3:0]      crc_left_q;
  logic [31:0]     b_q, div_q;
  logic [AW-1:0]   rem_q, rem_next;
  logic [AW:0]     rem_sh;
  logic [4:0]      bit_q;
  logic [AW-1:0]   idx_q [MAX_HASHES];
  logic [KW-1:0]   filled_q, filled_inc, ap_j_q;
  logic [RW-1:0]   round_q;
  logic [NW-1:0]   scan_i_q;
  logic            nonzero_q;
  logic            dup, hit;
  status_e         res_status_q;
  logic signed [1:0] res_side_q;
  logic [63:0]     res_key_q;
  logic [7:0]      res_count_q;
  logic [31:0]     res_hash_q;
  logic [63:0]     res_bkey_q;
  logic            out_valid_q;
  status_e         out_status_q;
  logic signed [1:0] out_side_q;
  logic [63:0]     out_key_q;
  logic [7:0]      out_count_q;
  logic [31:0]     out_hash_q;
  logic [63:0]     out_bkey_q;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  bucket_t         ram_wdata, rd;
  logic [$bits(bucket_t)-1:0] ram_rdata;

  ibf_ram #(
    .WIDTH($bits(bucket_t)),
    .DEPTH(BUCKETS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd = bucket_t'(ram_rdata);

  always_comb begin
    if (buckets_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(buckets_q) > 32'(BUCKETS)) begin
      n_eff = NW'(BUCKETS);
    end else begin
      n_eff = NW'(buckets_q);
    end
    k_tmp = (hash_count_q == '0) ? 5'd1 : {1'b0, hash_count_q};
    if (32'(k_tmp) > 32'(MAX_HASHES)) begin
      k_tmp = 5'(MAX_HASHES);
    end
    if (32'(k_tmp) > 32'(n_eff)) begin
      k_tmp = 5'(n_eff);
    end
    k_eff = KW'(k_tmp);
  end

  always_comb begin
    rem_sh = {rem_q, div_q[31]};
    if (rem_sh >= (AW+1)'(n_q)) begin
      rem_next = AW'(rem_sh - (AW+1)'(n_q));
    end else begin
      rem_next = rem_sh[AW-1:0];
    end
  end

  always_comb begin
    dup = 1'b0;
    hit = 1'b0;
    for (int j = 0; j < MAX_HASHES; j++) begin
      if (KW'(j) < filled_q && idx_q[j] == rem_q) begin
        dup = 1'b1;
      end
      if (KW'(j) < filled_q && idx_q[j] == AW'(scan_i_q)) begin
        hit = 1'b1;
      end
    end
    filled_inc = dup ? filled_q : filled_q + KW'(1);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[ap_j_q[JW-1:0]];
    ram_raddr = idx_q[ap_j_q[JW-1:0]];
    ram_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_AP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{count: rd.count + delta_q, key: rd.key ^ key_q, hash: rd.hash ^ h_q};
      end
      S_SC_RD: begin
        ram_raddr = AW'(scan_i_q);
      end
      S_BK_RD: begin
        ram_raddr = AW'(bi_q);
      end
      S_BK_EX: begin
        ram_waddr = AW'(bi_q);
        if (op_q == OP_LOAD) begin
          ram_we    = 1'b1;
          ram_wdata = '{count: cin_q, key: kin_q, hash: hin_q};
        end else if (op_q == OP_SUBTRACT) begin
          ram_we    = 1'b1;
          ram_wdata = '{count: rd.count - cin_q, key: rd.key ^ kin_q, hash: rd.hash ^ hin_q};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      hash_count_q <= 4'd3;
      buckets_q    <= 11'd1024;
      filled_q     <= '0;
      k_q          <= KW'(1);
      n_q          <= NW'(1);
      ap_j_q       <= '0;
      scan_i_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HASH_COUNT: hash_count_q <= cfg_data_i[3:0];
          CFG_BUCKETS:    buckets_q    <= cfg_data_i;
          default:        hash_count_q <= hash_count_q;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= op_e'(opcode_i);
            key_q        <= element_key_i;
            bi_q         <= bucket_index_i;
            cin_q        <= bucket_count_in_i;
            hin_q        <= bucket_hash_in_i;
            kin_q        <= bucket_key_in_i;
            n_q          <= n_eff;
            k_q          <= k_eff;
            filled_q     <= '0;
            res_status_q <= ST_DONE;
            res_side_q   <= '0;
            res_key_q    <= '0;
            res_count_q  <= '0;
            res_hash_q   <= '0;
            res_bkey_q   <= '0;
            unique case (op_e'(opcode_i))
              OP_INSERT, OP_REMOVE: begin
                delta_q  <= (op_e'(opcode_i) == OP_INSERT) ? 8'h01 : 8'hFF;
                ix_ret_q <= S_HASH_ST;
                state_q  <= S_IX_START;
              end
              OP_DECODE: begin
                scan_i_q  <= '0;
                nonzero_q <= 1'b0;
                state_q   <= S_SC_RD;
              end
              OP_LOAD, OP_SUBTRACT, OP_READ: begin
                state_q <= (32'(bucket_index_i) < 32'(n_eff)) ? S_BK_RD : S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_CRC: begin
          crc_q      <= crc_byte(crc_q, crc_data_q[7:0]);
          crc_data_q <= crc_data_q >> 8;
          crc_left_q <= crc_left_q - 4'd1;
          if (crc_left_q == 4'd1) begin
            state_q <= crc_ret_q;
          end
        end
        S_IX_START: begin
          filled_q   <= '0;
          round_q    <= '0;
          crc_q      <= 32'hFFFFFFFF;
          crc_data_q <= key_q;
          crc_left_q <= 4'd8;
          crc_ret_q  <= S_IX_MOD;
          state_q    <= S_CRC;
        end
        S_IX_MOD: begin
          b_q     <= ~crc_q;
          div_q   <= ~crc_q;
          rem_q   <= '0;
          bit_q   <= 5'd31;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_next;
          div_q <= div_q << 1;
          bit_q <= bit_q - 5'd1;
          if (bit_q == 5'd0) begin
            state_q <= S_IX_CHK;
          end
        end
        S_IX_CHK: begin
          if (!dup) begin
            idx_q[filled_q[JW-1:0]] <= rem_q;
          end
          filled_q <= filled_inc;
          round_q  <= round_q + RW'(1);
          if (filled_inc < k_q && round_q < RW'(ROUND_LIMIT - 1)) begin
            crc_q      <= 32'hFFFFFFFF;
            crc_data_q <= {b_q, 32'(round_q)};
            crc_left_q <= 4'd8;
            crc_ret_q  <= S_IX_MOD;
            state_q    <= S_CRC;
          end else begin
            state_q <= ix_ret_q;
          end
        end
        S_HASH_ST: begin
          crc_q      <= 32'hFFFFFFFF;
          crc_data_q <= key_q;
          crc_left_q <= 4'd4;
          crc_ret_q  <= S_HASH_END;
          state_q    <= S_CRC;
        end
        S_HASH_END: begin
          h_q     <= ~crc_q;
          ap_j_q  <= '0;
          state_q <= S_AP_RD;
        end
        S_AP_RD: begin
          state_q <= (ap_j_q == filled_q) ? S_DONE : S_AP_WR;
        end
        S_AP_WR: begin
          ap_j_q  <= ap_j_q + KW'(1);
          state_q <= S_AP_RD;
        end
        S_SC_RD: begin
          if (scan_i_q == n_q) begin
            res_status_q <= nonzero_q ? ST_FAILED : ST_EMPTY;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (rd != '0) begin
            nonzero_q <= 1'b1;
          end
          if (rd.count == 8'h01 || rd.count == 8'hFF) begin
            key_q      <= rd.key;
            hsum_q     <= rd.hash;
            pure_cnt_q <= rd.count;
            crc_q      <= 32'hFFFFFFFF;
            crc_data_q <= rd.key;
            crc_left_q <= 4'd4;
            crc_ret_q  <= S_SC_HASH;
            state_q    <= S_CRC;
          end else begin
            scan_i_q <= scan_i_q + NW'(1);
            state_q  <= S_SC_RD;
          end
        end
        S_SC_HASH: begin
          if (~crc_q == hsum_q) begin
            h_q      <= hsum_q;
            ix_ret_q <= S_SC_HIT;
            state_q  <= S_IX_START;
          end else begin
            scan_i_q <= scan_i_q + NW'(1);
            state_q  <= S_SC_RD;
          end
        end
        S_SC_HIT: begin
          if (hit) begin
            res_status_q <= ST_DECODED;
            res_side_q   <= (pure_cnt_q == 8'h01) ? 2'sd1 : -2'sd1;
            res_key_q    <= key_q;
            delta_q      <= 8'd0 - pure_cnt_q;
            ap_j_q       <= '0;
            state_q      <= S_AP_RD;
          end else begin
            scan_i_q <= scan_i_q + NW'(1);
            state_q  <= S_SC_RD;
          end
        end
        S_BK_RD: begin
          state_q <= S_BK_EX;
        end
        S_BK_EX: begin
          if (op_q == OP_READ) begin
            res_count_q <= rd.count;
            res_hash_q  <= rd.hash;
            res_bkey_q  <= rd.key;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_side_q   <= res_side_q;
            out_key_q    <= res_key_q;
            out_count_q  <= res_count_q;
            out_hash_q   <= res_hash_q;
            out_bkey_q   <= res_bkey_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign decoded_side_o     = out_side_q;
  assign decoded_key_o      = out_key_q;
  assign bucket_count_out_o = out_count_q;
  assign bucket_hash_out_o  = out_hash_q;
  assign bucket_key_out_o   = out_bkey_q;

  `IBF_ASSERT(a_filled_le_k, filled_q <= k_q)
  `IBF_ASSERT(a_apply_in_list, state_q == S_AP_WR |-> ap_j_q < filled_q)
  `IBF_ASSERT_NEXT(a_done_emits, state_q == S_DONE && !out_valid_q, out_valid_q)
  `IBF_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != S_IDLE)

endmodule

FILE: src/ibf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module ibf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
